FILE: src/cpt_pkg.sv
`timescale 1ns / 1ps
package cpt_pkg;

  localparam int TOKEN_COUNT_WIDTH = 24;
  localparam int LINE_COUNT_WIDTH  = 20;
  localparam int CMD_DEPTH         = 4;
  localparam int CMD_PTR_WIDTH     = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_WIDTH     = $clog2(CMD_DEPTH + 1);

  typedef logic [1:0] kind_t;
  typedef logic [5:0] code_t;

  localparam kind_t KIND_TOKEN = 2'd0;
  localparam kind_t KIND_ERROR = 2'd1;
  localparam kind_t KIND_END   = 2'd2;

  localparam code_t PC_LBRACK  = 6'd0;
  localparam code_t PC_RBRACK  = 6'd1;
  localparam code_t PC_LPAREN  = 6'd2;
  localparam code_t PC_RPAREN  = 6'd3;
  localparam code_t PC_LBRACE  = 6'd4;
  localparam code_t PC_RBRACE  = 6'd5;
  localparam code_t PC_QUEST   = 6'd6;
  localparam code_t PC_COLON   = 6'd7;
  localparam code_t PC_SEMI    = 6'd8;
  localparam code_t PC_COMMA   = 6'd9;
  localparam code_t PC_TILDE   = 6'd10;
  localparam code_t PC_PLUS    = 6'd11;
  localparam code_t PC_AMP     = 6'd12;
  localparam code_t PC_PIPE    = 6'd13;
  localparam code_t PC_LT      = 6'd14;
  localparam code_t PC_GT      = 6'd15;
  localparam code_t PC_MINUS   = 6'd16;
  localparam code_t PC_NOT     = 6'd17;
  localparam code_t PC_ASSIGN  = 6'd18;
  localparam code_t PC_STAR    = 6'd19;
  localparam code_t PC_SLASH   = 6'd20;
  localparam code_t PC_PERCENT = 6'd21;
  localparam code_t PC_CARET   = 6'd22;
  localparam code_t PC_INC     = 6'd23;
  localparam code_t PC_ADD_EQ  = 6'd24;
  localparam code_t PC_LAND    = 6'd25;
  localparam code_t PC_AND_EQ  = 6'd26;
  localparam code_t PC_LOR     = 6'd27;
  localparam code_t PC_OR_EQ   = 6'd28;
  localparam code_t PC_LE      = 6'd29;
  localparam code_t PC_SHL     = 6'd30;
  localparam code_t PC_GE      = 6'd31;
  localparam code_t PC_SHR     = 6'd32;
  localparam code_t PC_ARROW   = 6'd33;
  localparam code_t PC_DEC     = 6'd34;
  localparam code_t PC_SUB_EQ  = 6'd35;
  localparam code_t PC_NE      = 6'd36;
  localparam code_t PC_EQ      = 6'd37;
  localparam code_t PC_MUL_EQ  = 6'd38;
  localparam code_t PC_DIV_EQ  = 6'd39;
  localparam code_t PC_MOD_EQ  = 6'd40;
  localparam code_t PC_XOR_EQ  = 6'd41;
  localparam code_t PC_SHL_EQ  = 6'd42;
  localparam code_t PC_SHR_EQ  = 6'd43;

  typedef struct packed {
    logic  r0_valid;
    kind_t r0_kind;
    code_t r0_code;
    logic  r1_valid;
    kind_t r1_kind;
    code_t r1_code;
    logic  newline;
  } cmd_t;

endpackage

FILE: src/cpt_front.sv
`timescale 1ns / 1ps
module cpt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    ch,
  input  logic          push,
  input  logic          fifo_full,
  output logic          full,
  output logic          cmd_wr,
  output cpt_pkg::cmd_t cmd
);
  import cpt_pkg::*;

  typedef enum logic [7:0] {
    MODE_IDLE  = 8'b0000_0001,
    MODE_PLUS  = 8'b0000_0010,
    MODE_AMP   = 8'b0000_0100,
    MODE_PIPE  = 8'b0000_1000,
    MODE_LT    = 8'b0001_0000,
    MODE_GT    = 8'b0010_0000,
    MODE_MINUS = 8'b0100_0000,
    MODE_EQ    = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    logic  res;
    kind_t kind;
    code_t code;
    mode_t mode;
    code_t pend;
    logic  newline;
    logic  halt;
  } idle_t;

  mode_t mode, mode_next;
  code_t pend, pend_next;
  logic  halted, halted_next;
  logic  accept;
  logic  done_v;
  code_t done_c;
  idle_t idle_r;

  function automatic idle_t handle_idle(input logic [7:0] c);
    idle_t r;
    r = '{res: 1'b0, kind: KIND_TOKEN, code: '0, mode: MODE_IDLE, pend: '0,
          newline: 1'b0, halt: 1'b0};
    case (c)
      8'h00: begin
        r.res = 1'b1; r.kind = KIND_END; r.halt = 1'b1;
      end
      "[": begin r.res = 1'b1; r.code = PC_LBRACK; end
      "]": begin r.res = 1'b1; r.code = PC_RBRACK; end
      "(": begin r.res = 1'b1; r.code = PC_LPAREN; end
      ")": begin r.res = 1'b1; r.code = PC_RPAREN; end
      "{": begin r.res = 1'b1; r.code = PC_LBRACE; end
      "}": begin r.res = 1'b1; r.code = PC_RBRACE; end
      "?": begin r.res = 1'b1; r.code = PC_QUEST; end
      ":": begin r.res = 1'b1; r.code = PC_COLON; end
      ";": begin r.res = 1'b1; r.code = PC_SEMI; end
      ",": begin r.res = 1'b1; r.code = PC_COMMA; end
      "~": begin r.res = 1'b1; r.code = PC_TILDE; end
      "+": begin r.mode = MODE_PLUS;  r.pend = PC_PLUS; end
      "&": begin r.mode = MODE_AMP;   r.pend = PC_AMP; end
      "|": begin r.mode = MODE_PIPE;  r.pend = PC_PIPE; end
      "<": begin r.mode = MODE_LT;    r.pend = PC_LT; end
      ">": begin r.mode = MODE_GT;    r.pend = PC_GT; end
      "-": begin r.mode = MODE_MINUS; r.pend = PC_MINUS; end
      "!": begin r.mode = MODE_EQ;    r.pend = PC_NOT; end
      "=": begin r.mode = MODE_EQ;    r.pend = PC_ASSIGN; end
      "*": begin r.mode = MODE_EQ;    r.pend = PC_STAR; end
      "/": begin r.mode = MODE_EQ;    r.pend = PC_SLASH; end
      "%": begin r.mode = MODE_EQ;    r.pend = PC_PERCENT; end
      "^": begin r.mode = MODE_EQ;    r.pend = PC_CARET; end
      " ", "\t": begin
        r.res = 1'b0;
      end
      "\n": begin
        r.newline = 1'b1;
      end
      default: begin
        if (!((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))) begin
          r.res  = 1'b1;
          r.kind = KIND_ERROR;
          r.halt = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic code_t eq_form(input code_t p);
    code_t r;
    r = p;
    case (p)
      PC_NOT:     r = PC_NE;
      PC_ASSIGN:  r = PC_EQ;
      PC_STAR:    r = PC_MUL_EQ;
      PC_SLASH:   r = PC_DIV_EQ;
      PC_PERCENT: r = PC_MOD_EQ;
      PC_CARET:   r = PC_XOR_EQ;
      PC_SHL:     r = PC_SHL_EQ;
      PC_SHR:     r = PC_SHR_EQ;
      default:    r = p;
    endcase
    return r;
  endfunction

  assign full   = fifo_full;
  assign accept = push && !fifo_full;
  assign cmd_wr = accept && (cmd.r0_valid || cmd.newline);

  always_comb begin
    idle_r      = handle_idle(ch);
    cmd         = '0;
    mode_next   = mode;
    pend_next   = pend;
    halted_next = halted;
    done_v      = 1'b0;
    done_c      = '0;

    unique case (mode)
      MODE_IDLE: begin
        done_v = 1'b0;
      end
      MODE_PLUS: begin
        if (ch == "+") begin done_v = 1'b1; done_c = PC_INC; end
        else if (ch == "=") begin done_v = 1'b1; done_c = PC_ADD_EQ; end
      end
      MODE_AMP: begin
        if (ch == "&") begin done_v = 1'b1; done_c = PC_LAND; end
        else if (ch == "=") begin done_v = 1'b1; done_c = PC_AND_EQ; end
      end
      MODE_PIPE: begin
        if (ch == "|") begin done_v = 1'b1; done_c = PC_LOR; end
        else if (ch == "=") begin done_v = 1'b1; done_c = PC_OR_EQ; end
      end
      MODE_LT: begin
        if (ch == "=") begin done_v = 1'b1; done_c = PC_LE; end
      end
      MODE_GT: begin
        if (ch == "=") begin done_v = 1'b1; done_c = PC_GE; end
      end
      MODE_MINUS: begin
        if (ch == ">") begin done_v = 1'b1; done_c = PC_ARROW; end
        else if (ch == "-") begin done_v = 1'b1; done_c = PC_DEC; end
        else if (ch == "=") begin done_v = 1'b1; done_c = PC_SUB_EQ; end
      end
      MODE_EQ: begin
        if (ch == "=") begin done_v = 1'b1; done_c = eq_form(pend); end
      end
      default: begin
        done_v = 1'b0;
      end
    endcase

    if (!halted) begin
      if (mode == MODE_IDLE) begin
        cmd.r0_valid = idle_r.res;
        cmd.r0_kind  = idle_r.kind;
        cmd.r0_code  = idle_r.code;
        cmd.newline  = idle_r.newline;
        mode_next    = idle_r.mode;
        pend_next    = idle_r.pend;
        halted_next  = idle_r.halt;
      end else if ((mode == MODE_LT && ch == "<") || (mode == MODE_GT && ch == ">")) begin
        mode_next = MODE_EQ;
        pend_next = (mode == MODE_LT) ? PC_SHL : PC_SHR;
      end else if (done_v) begin
        cmd.r0_valid = 1'b1;
        cmd.r0_kind  = KIND_TOKEN;
        cmd.r0_code  = done_c;
        mode_next    = MODE_IDLE;
        pend_next    = '0;
      end else begin
        // flush the pending operator, then treat the byte as new
        cmd.r0_valid = 1'b1;
        cmd.r0_kind  = KIND_TOKEN;
        cmd.r0_code  = pend;
        cmd.r1_valid = idle_r.res;
        cmd.r1_kind  = idle_r.kind;
        cmd.r1_code  = idle_r.code;
        cmd.newline  = idle_r.newline;
        mode_next    = idle_r.mode;
        pend_next    = idle_r.pend;
        halted_next  = idle_r.halt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      pend   <= '0;
      halted <= 1'b0;
    end else if (accept) begin
      mode   <= mode_next;
      pend   <= pend_next;
      halted <= halted_next;
    end
  end

  a_halt_holds: assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halted dropped without reset");
  a_halt_idle: assert property (@(posedge clk) disable iff (rst)
    halted |-> (mode == MODE_IDLE))
    else $error("pending operator while halted");
  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    cmd_wr |-> (!cmd.r1_valid || cmd.r0_valid))
    else $error("second result without first");

endmodule

FILE: src/cpt_cmd_fifo.sv
`timescale 1ns / 1ps
module cpt_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  cpt_pkg::cmd_t wr_data,
  input  logic          rd,
  output logic          fifo_full,
  output logic          head_valid,
  output cpt_pkg::cmd_t head
);
  import cpt_pkg::*;

  cmd_t                     entries [CMD_DEPTH];
  logic [CMD_PTR_WIDTH-1:0] wr_ptr;
  logic [CMD_PTR_WIDTH-1:0] rd_ptr;
  logic [CMD_CNT_WIDTH-1:0] count;
  logic                     do_wr;
  logic                     do_rd;

  assign fifo_full  = (count == CMD_CNT_WIDTH'(CMD_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_wr      = wr && !fifo_full;
  assign do_rd      = rd && head_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + CMD_PTR_WIDTH'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + CMD_PTR_WIDTH'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CMD_CNT_WIDTH'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CMD_CNT_WIDTH'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CMD_CNT_WIDTH'(CMD_DEPTH))
    else $error("command queue count out of range");

endmodule

FILE: src/cpt_back.sv
`timescale 1ns / 1ps
module cpt_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  head_valid,
  input  cpt_pkg::cmd_t                         head,
  output logic                                  cmd_rd,
  input  logic                                  pop,
  output logic                                  empty,
  output logic [1:0]                            kind,
  output logic [5:0]                            punct_code,
  output logic [cpt_pkg::TOKEN_COUNT_WIDTH-1:0] token_number,
  output logic [cpt_pkg::LINE_COUNT_WIDTH-1:0]  line_number,
  output logic                                  last
);
  import cpt_pkg::*;

  logic                         out_valid;
  logic                         phase;
  logic [TOKEN_COUNT_WIDTH-1:0] token_count;
  logic [LINE_COUNT_WIDTH-1:0]  line_count;
  logic                         has_res;
  logic                         load;
  logic                         slot_last;
  kind_t                        slot_kind;
  code_t                        slot_code;
  logic                         skip;

  assign has_res   = head.r0_valid;
  assign load      = head_valid && has_res && (!out_valid || pop);
  assign skip      = head_valid && !has_res;
  assign slot_last = phase || !head.r1_valid;
  assign slot_kind = phase ? head.r1_kind : head.r0_kind;
  assign slot_code = phase ? head.r1_code : head.r0_code;
  assign cmd_rd    = skip || (load && slot_last);
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      kind         <= slot_kind;
      punct_code   <= slot_code;
      token_number <= token_count;
      line_number  <= line_count;
      last         <= slot_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      phase       <= 1'b0;
      token_count <= TOKEN_COUNT_WIDTH'(1);
      line_count  <= LINE_COUNT_WIDTH'(1);
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        phase <= !slot_last;
      end
      // saturate at all ones
      if (load && slot_kind == KIND_TOKEN && token_count != '1) begin
        token_count <= token_count + TOKEN_COUNT_WIDTH'(1);
      end
      if (cmd_rd && head.newline && line_count != '1) begin
        line_count <= line_count + LINE_COUNT_WIDTH'(1);
      end
    end
  end

  a_phase_second: assert property (@(posedge clk) disable iff (rst)
    phase |-> (head_valid && head.r1_valid))
    else $error("second slot selected without a second result");
  a_token_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (token_count >= $past(token_count)))
    else $error("token count went backward");

endmodule

FILE: src/c_punctuator_tokenizer.sv
`timescale 1ns / 1ps
// C punctuator tokenizer.
// Input queue: drive ch and push; a word is taken on a clock edge with push
// high and full low. Result queue: while empty is low the oldest result word
// sits on kind, punct_code, token_number, line_number and last; pop high
// takes it.
// The front scanner classifies each word in the cycle it is taken and writes
// a command to a four-entry queue; the back end keeps the token and line
// counters and emits results through one output register.
// A word's command is written to the command queue; its results are then
// loaded into the output register. Throughput: one word per cycle while full
// is low; a word that flushes a pending operator and makes a second result
// loads the single output register twice, one result per cycle while popped.
// Reset clears the scanner, empties both queues and sets both counters to 1.
// After an error or end result the block takes and drops every word until
// reset. When the receiver stalls, results hold, the command queue fills and
// full rises after four more commands.
module c_punctuator_tokenizer (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [7:0]                            ch,
  input  logic                                  push,
  output logic                                  full,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [1:0]                            kind,
  output logic [5:0]                            punct_code,
  output logic [cpt_pkg::TOKEN_COUNT_WIDTH-1:0] token_number,
  output logic [cpt_pkg::LINE_COUNT_WIDTH-1:0]  line_number,
  output logic                                  last
);
  import cpt_pkg::*;

  cmd_t cmd;
  cmd_t head;
  logic cmd_wr;
  logic cmd_rd;
  logic fifo_full;
  logic head_valid;

  cpt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ch        (ch),
    .push      (push),
    .fifo_full (fifo_full),
    .full      (full),
    .cmd_wr    (cmd_wr),
    .cmd       (cmd)
  );

  cpt_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr         (cmd_wr),
    .wr_data    (cmd),
    .rd         (cmd_rd),
    .fifo_full  (fifo_full),
    .head_valid (head_valid),
    .head       (head)
  );

  cpt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .cmd_rd       (cmd_rd),
    .pop          (pop),
    .empty        (empty),
    .kind         (kind),
    .punct_code   (punct_code),
    .token_number (token_number),
    .line_number  (line_number),
    .last         (last)
  );

endmodule
